// ===== rtl/hafc_pkg.sv =====
// Shared types and constants of the hex line frame checker.
package hafc_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 1024;
  localparam int unsigned CMD_FIFO_DEPTH      = 2;
  localparam int unsigned OUT_FIFO_DEPTH      = 2;
  localparam int unsigned FRAME_W             = 11;

  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  START_MARK = 8'h24;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_START  = 3'd1,
    ST_BAD_HEX   = 3'd2,
    ST_ODD       = 3'd3,
    ST_SHORT     = 3'd4,
    ST_CRC_BAD   = 3'd5,
    ST_TOO_LONG  = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_word_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         data_byte;
    status_e            status;
    logic [FRAME_W-1:0] frame_bytes;
    logic [7:0]         command_id;
    logic               last;
  } out_word_t;

  // Work handed from the parser to the checksum stage.
  typedef struct packed {
    logic               emit;
    logic [7:0]         data_byte;
    logic               eol;
    status_e            status;
    logic               chk_crc;
    logic [FRAME_W-1:0] frame_bytes;
    logic [7:0]         command_id;
    logic [15:0]        exp_crc;
  } cmd_t;

endpackage

// ===== rtl/hex_ascii_frame_crc16_checker_unit.sv =====
// Top level of the hex line frame checker with CRC-16/ARC.
// Usage:
//   Input queue: drive in_word_i and push_i; a character word is taken at a clock
//   edge where push_i is high and full_o is low. end_of_line marks the line's last
//   character.
//   Result queue: while empty_o is low the oldest result word is on out_word_o;
//   it is taken at an edge where pop_i is high. Frame bytes come out as kind 0,
//   and every line ends in one status word (kind 1, last 1).
// Path: the first result word of a character enters the command queue at the edge
//   that takes it and the result queue when the checksum stage takes it; a status
//   word behind a frame byte of the same character follows that byte.
// Throughput: one character per cycle while full_o is low; the parser feeds a two-word
//   command queue and the checksum stage writes one result word per cycle while the
//   result queue has room. A line end that also releases a frame byte yields a byte
//   word, then a status word; a one-character line right behind it finds full_o high.
// Reset: all line state clears and both queues empty; the first character after
//   reset starts the hunt for the start mark.
// Stalls: when pop_i stays low the result and command queues fill and full_o
//   rises; nothing is dropped.
module hex_ascii_frame_crc16_checker_unit
  import hafc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_word_t  in_word_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_word_t out_word_o
);

  logic      accept;
  logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t      cmd_wr, cmd_rd;
  logic      out_push, out_full;
  out_word_t out_wr;

  assign full_o = cmd_full;
  assign accept = push_i && !cmd_full;

  hafc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_wr)
  );

  hafc_fifo #(
    .DEPTH(CMD_FIFO_DEPTH),
    .T    (cmd_t)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_wr),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .rdata_o(cmd_rd)
  );

  hafc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_rd),
    .cmd_pop_o  (cmd_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_word_o (out_wr)
  );

  hafc_fifo #(
    .DEPTH(OUT_FIFO_DEPTH),
    .T    (out_word_t)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(out_wr),
    .full_o (out_full),
    .pop_i  (pop_i),
    .empty_o(empty_o),
    .rdata_o(out_word_o)
  );

endmodule

// ===== rtl/hafc_fifo.sv =====
// Small register queue with a typed word.
module hafc_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type         T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output T     rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T               mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/hafc_front.sv =====
// Character parser: start mark, hex pairing, delay line, counts and status precursors.
module hafc_front
  import hafc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_word_t in_word_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 4);
  localparam int unsigned FBW   = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(MAX_FRAME_BYTES + 3);
  localparam logic [CNT_W-1:0] CNT_EMIT = CNT_W'(MAX_FRAME_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FRAME_BYTES);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  logic             in_frame_q, in_frame_d;
  logic             nib_q, nib_d;
  logic [3:0]       hi_q, hi_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       dly0_q, dly0_d;
  logic [7:0]       dly1_q, dly1_d;
  logic [7:0]       first_q, first_d;
  logic             err_q, err_d;
  logic             trail_q, trail_d;

  logic [7:0]       c;
  logic             is_space, is_hex;
  logic [3:0]       hex_val;
  logic             emit;
  logic [7:0]       emit_byte;
  logic [CNT_W-1:0] fb_cnt;
  logic [FBW-1:0]   fb_wide;
  status_e          pre_status;
  logic             chk_crc;

  assign c = in_word_i.char_code;

  always_comb begin
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    is_hex   = 1'b1;
    hex_val  = '0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      hex_val = 4'(c - CH_0);
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      hex_val = 4'(c - CH_UA + 8'd10);
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      hex_val = 4'(c - CH_LA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    nib_d      = nib_q;
    hi_d       = hi_q;
    cnt_d      = cnt_q;
    dly0_d     = dly0_q;
    dly1_d     = dly1_q;
    first_d    = first_q;
    err_d      = err_q;
    trail_d    = trail_q;
    emit       = 1'b0;
    emit_byte  = dly0_q;

    if (!in_frame_q) begin
      if (c == START_MARK) begin
        in_frame_d = 1'b1;
      end
    end else if (!err_q) begin
      if (is_space) begin
        trail_d = 1'b1;
      end else if (!is_hex || trail_q) begin
        err_d = 1'b1;
      end else if (!nib_q) begin
        hi_d  = hex_val;
        nib_d = 1'b1;
      end else begin
        nib_d = 1'b0;
        // The byte leaving the delay line is a frame byte unless the frame is over length.
        if ((cnt_q >= CNT_W'(2)) && (cnt_q < CNT_EMIT)) begin
          emit = 1'b1;
          if (cnt_q == CNT_W'(2)) begin
            first_d = dly0_q;
          end
        end
        dly0_d = dly1_q;
        dly1_d = {hi_q, hex_val};
        if (cnt_q < CNT_SAT) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
    end

    fb_cnt = (cnt_d >= CNT_W'(2)) ? cnt_d - CNT_W'(2) : '0;
    if (fb_cnt > CNT_MAX) begin
      fb_cnt = CNT_MAX;
    end
    fb_wide = FBW'(fb_cnt);

    chk_crc = 1'b0;
    if (!in_frame_d) begin
      pre_status = ST_NO_START;
    end else if (err_d) begin
      pre_status = ST_BAD_HEX;
    end else if (nib_d) begin
      pre_status = ST_ODD;
    end else if (cnt_d > CNT_EMIT) begin
      pre_status = ST_TOO_LONG;
    end else if (cnt_d < CNT_W'(3)) begin
      pre_status = ST_SHORT;
    end else begin
      pre_status = ST_OK;
      chk_crc    = 1'b1;
    end
  end

  always_comb begin
    cmd_o.emit        = emit;
    cmd_o.data_byte   = emit_byte;
    cmd_o.eol         = in_word_i.end_of_line;
    cmd_o.status      = pre_status;
    cmd_o.chk_crc     = chk_crc;
    cmd_o.frame_bytes = fb_wide[FRAME_W-1:0];
    cmd_o.command_id  = first_d;
    cmd_o.exp_crc     = {dly1_d, dly0_d};
  end

  assign cmd_push_o = accept_i && (emit || in_word_i.end_of_line);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      nib_q      <= 1'b0;
      hi_q       <= '0;
      cnt_q      <= '0;
      dly0_q     <= '0;
      dly1_q     <= '0;
      first_q    <= '0;
      err_q      <= 1'b0;
      trail_q    <= 1'b0;
    end else if (accept_i) begin
      if (in_word_i.end_of_line) begin
        in_frame_q <= 1'b0;
        nib_q      <= 1'b0;
        hi_q       <= '0;
        cnt_q      <= '0;
        dly0_q     <= '0;
        dly1_q     <= '0;
        first_q    <= '0;
        err_q      <= 1'b0;
        trail_q    <= 1'b0;
      end else begin
        in_frame_q <= in_frame_d;
        nib_q      <= nib_d;
        hi_q       <= hi_d;
        cnt_q      <= cnt_d;
        dly0_q     <= dly0_d;
        dly1_q     <= dly1_d;
        first_q    <= first_d;
        err_q      <= err_d;
        trail_q    <= trail_d;
      end
    end
  end

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && in_word_i.end_of_line) |=> (!in_frame_q && (cnt_q == '0) && !err_q))
    else $error("line state not cleared after end of line");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && emit) |-> ((cnt_q >= CNT_W'(2)) && in_frame_q && nib_q))
    else $error("frame byte emitted without two bytes in the delay line");

  a_err_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q || trail_q || nib_q) |-> in_frame_q)
    else $error("decode state set outside a frame");

endmodule

// ===== rtl/hafc_back.sv =====
// Checksum stage: CRC-16/ARC over frame bytes and result sequencing.
module hafc_back
  import hafc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_empty_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      out_full_i,
  output logic      out_push_o,
  output out_word_t out_word_o
);

  logic [15:0] crc_q, crc_d;
  logic        byte_done_q, byte_done_d;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b_in);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = crc_in;
    b   = b_in;
    for (int i = 0; i < 8; i++) begin
      if (b[0] ^ crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

  always_comb begin
    crc_d       = crc_q;
    byte_done_d = byte_done_q;
    cmd_pop_o   = 1'b0;
    out_push_o  = 1'b0;
    out_word_o  = '0;

    if (!cmd_empty_i && !out_full_i) begin
      if (cmd_i.emit && !byte_done_q) begin
        out_push_o           = 1'b1;
        out_word_o.data_byte = cmd_i.data_byte;
        crc_d                = crc16_byte(crc_q, cmd_i.data_byte);
        // A word that also ends the line stays at the head for its status result.
        if (cmd_i.eol) begin
          byte_done_d = 1'b1;
        end else begin
          cmd_pop_o = 1'b1;
        end
      end else if (cmd_i.eol) begin
        out_push_o             = 1'b1;
        out_word_o.kind        = 1'b1;
        out_word_o.frame_bytes = cmd_i.frame_bytes;
        out_word_o.command_id  = cmd_i.command_id;
        out_word_o.last        = 1'b1;
        if (cmd_i.chk_crc) begin
          out_word_o.status = (crc_q == cmd_i.exp_crc) ? ST_OK : ST_CRC_BAD;
        end else begin
          out_word_o.status = cmd_i.status;
        end
        crc_d       = '0;
        byte_done_d = 1'b0;
        cmd_pop_o   = 1'b1;
      end else begin
        cmd_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= '0;
      byte_done_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      byte_done_q <= byte_done_d;
    end
  end

  a_done_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_done_q |-> (!cmd_empty_i && cmd_i.eol && cmd_i.emit))
    else $error("pending status without a matching head word");

  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && out_word_o.last) |=> (crc_q == '0))
    else $error("checksum not restarted after a status result");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (!cmd_empty_i && !byte_done_d))
    else $error("command popped while its status is still owed");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the hex line frame checker with CRC-16/ARC.
`timescale 1ns / 100ps

module tb;
  import hafc_pkg::*;

  localparam int unsigned MAX_BYTES   = MAX_FRAME_BYTES_DEF;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 20;

  typedef enum int {
    SH_CLEAN,
    SH_BAD_CRC,
    SH_ODD,
    SH_BAD_CHAR,
    SH_MID_SPACE,
    SH_NO_MARK
  } shape_e;

  typedef struct {
    in_word_t  w;
    logic      typed;
    out_word_t want;
  } stim_row_t;

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      push_i     = 1'b0;
  in_word_t  in_word_i  = '0;
  logic      pop_i      = 1'b0;
  logic      full_o;
  logic      empty_o;
  out_word_t out_word_o;

  // Line decoder state as seen from outside.
  logic        in_line    = 1'b0;
  logic        nib_half   = 1'b0;
  logic [3:0]  hi_nib     = '0;
  int unsigned dec_count  = 0;
  logic [7:0]  dly [2]    = '{8'h00, 8'h00};
  logic [15:0] crc_acc    = '0;
  logic [7:0]  cmd_byte   = '0;
  logic        bad_char   = 1'b0;
  logic        space_seen = 1'b0;

  out_word_t   owed_q [$];
  stim_row_t   rows [$];
  in_word_t    line_q [$];
  int unsigned mismatches = 0;
  int unsigned chars_sent = 0;
  int unsigned tx_burst   = 0;
  int unsigned rx_burst   = 0;
  logic        hold_req   = 1'b0;

  hex_ascii_frame_crc16_checker_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_word_i  (in_word_i),
    .full_o     (full_o),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_word_o (out_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc16_arc_byte(logic [15:0] crc, logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      if (crc[0] ^ b[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] ws_char();
    int unsigned sel;
    sel = $urandom_range(0, 5);
    return (sel == 0) ? 8'h20 : 8'h08 + sel[7:0];
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  // Mostly back to back, often short gaps, now and then a long one or a burst.
  function automatic int unsigned pick_gap(ref int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic decode_char(in_word_t w);
    int          hv;
    logic [7:0]  c;
    logic [7:0]  nb;
    int unsigned fb;
    status_e     st;
    out_word_t   o;
    c  = w.char_code;
    hv = hex_val(c);
    if (!in_line) begin
      if (c == START_MARK) in_line = 1'b1;
    end else if (!bad_char) begin
      if (is_ws(c)) begin
        space_seen = 1'b1;
      end else if (hv < 0 || space_seen) begin
        bad_char = 1'b1;
      end else if (!nib_half) begin
        hi_nib   = hv[3:0];
        nib_half = 1'b1;
      end else begin
        nb       = {hi_nib, hv[3:0]};
        nib_half = 1'b0;
        // The two newest bytes are held back; they may turn out to be the checksum.
        if (dec_count >= 2 && dec_count - 2 < MAX_BYTES) begin
          if (dec_count == 2) cmd_byte = dly[0];
          crc_acc     = crc16_arc_byte(crc_acc, dly[0]);
          o           = '0;
          o.data_byte = dly[0];
          owed_q.insert(owed_q.size(), o);
        end
        dly[0] = dly[1];
        dly[1] = nb;
        if (dec_count < MAX_BYTES + 3) dec_count++;
      end
    end
    if (w.end_of_line) begin
      fb = (dec_count >= 2) ? dec_count - 2 : 0;
      if (fb > MAX_BYTES) fb = MAX_BYTES;
      if (!in_line) st = ST_NO_START;
      else if (bad_char) st = ST_BAD_HEX;
      else if (nib_half) st = ST_ODD;
      else if (dec_count > MAX_BYTES + 2) st = ST_TOO_LONG;
      else if (dec_count < 3) st = ST_SHORT;
      else if (crc_acc != {dly[1], dly[0]}) st = ST_CRC_BAD;
      else st = ST_OK;
      o             = '0;
      o.kind        = 1'b1;
      o.status      = st;
      o.frame_bytes = fb[FRAME_W-1:0];
      o.command_id  = cmd_byte;
      o.last        = 1'b1;
      owed_q.insert(owed_q.size(), o);
      in_line    = 1'b0;
      nib_half   = 1'b0;
      hi_nib     = '0;
      dec_count  = 0;
      dly[0]     = '0;
      dly[1]     = '0;
      crc_acc    = '0;
      cmd_byte   = '0;
      bad_char   = 1'b0;
      space_seen = 1'b0;
    end
  endtask

  task automatic add_line(string s, logic typed, status_e st, int unsigned nbytes,
                          logic [7:0] cmd);
    stim_row_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.w.char_code   = s[i];
      r.w.end_of_line = (i == s.len() - 1);
      r.typed         = typed && (i == s.len() - 1);
      r.want          = '{kind: 1'b1, data_byte: 8'h00, status: st,
                          frame_bytes: nbytes[FRAME_W-1:0], command_id: cmd, last: 1'b1};
      rows.insert(rows.size(), r);
    end
  endtask

  task automatic make_line(int unsigned nbytes, shape_e shape);
    logic [7:0]  pay [$];
    logic [15:0] crc;
    logic [7:0]  c;
    int unsigned pos;
    int unsigned nhead;
    line_q.delete();
    crc   = '0;
    nhead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (nhead) begin
      do c = 8'($urandom_range(0, 255)); while (c == START_MARK);
      line_q.insert(line_q.size(), '{char_code: c, end_of_line: 1'b0});
    end
    if (shape != SH_NO_MARK) begin
      line_q.insert(line_q.size(), '{char_code: START_MARK, end_of_line: 1'b0});
    end
    pos = line_q.size();
    repeat (nbytes) begin
      c   = 8'($urandom_range(0, 255));
      crc = crc16_arc_byte(crc, c);
      pay.insert(pay.size(), c);
    end
    if (shape == SH_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    pay.insert(pay.size(), crc[7:0]);
    pay.insert(pay.size(), crc[15:8]);
    foreach (pay[i]) begin
      line_q.insert(line_q.size(), '{char_code: hex_char(pay[i][7:4]), end_of_line: 1'b0});
      line_q.insert(line_q.size(), '{char_code: hex_char(pay[i][3:0]), end_of_line: 1'b0});
    end
    if (shape == SH_ODD) begin
      line_q.insert(line_q.size(),
                    '{char_code: hex_char(4'($urandom_range(0, 15))), end_of_line: 1'b0});
    end
    if (shape == SH_BAD_CHAR) begin
      do c = 8'($urandom_range(0, 255)); while (hex_val(c) >= 0 || is_ws(c));
      line_q.insert($urandom_range(pos, line_q.size()), '{char_code: c, end_of_line: 1'b0});
    end
    // Whitespace with digits after it is an error too.
    if (shape == SH_MID_SPACE) begin
      line_q.insert($urandom_range(pos + 1, line_q.size() - 1),
                    '{char_code: ws_char(), end_of_line: 1'b0});
    end
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        line_q.insert(line_q.size(), '{char_code: ws_char(), end_of_line: 1'b0});
      end
    end
    line_q[line_q.size() - 1].end_of_line = 1'b1;
  endtask

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(in_word_t w);
    int unsigned gap;
    logic        took;
    gap = hold_req ? 0 : pick_gap(tx_burst);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_word_i <= w;
    do begin
      @(negedge clk_i);
      took = !full_o;
      @(posedge clk_i);
    end while (!took);
    chars_sent++;
    decode_char(w);
  endtask

  task automatic send_random_line();
    int unsigned r;
    int unsigned n;
    shape_e      shape;
    r = $urandom_range(0, 9);
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    if (r <= 5) shape = SH_CLEAN;
    else if (r == 6) shape = SH_BAD_CRC;
    else if (r == 7) shape = SH_ODD;
    else if (r == 8) shape = $urandom_range(0, 1) ? SH_BAD_CHAR : SH_MID_SPACE;
    else shape = SH_NO_MARK;
    make_line(n, shape);
    foreach (line_q[i]) send_word(line_q[i]);
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (owed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected word kind=%0d byte=%02h st=%0d len=%0d cmd=%02h last=%0d",
                 $realtime, got.kind, got.data_byte, got.status, got.frame_bytes,
                 got.command_id, got.last);
      end
    end else begin
      want = owed_q.pop_front();
      if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
          got.status !== want.status || got.frame_bytes !== want.frame_bytes ||
          got.command_id !== want.command_id || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch want kind=%0d byte=%02h st=%0d len=%0d cmd=%02h last=%0d",
                   $realtime, want.kind, want.data_byte, want.status, want.frame_bytes,
                   want.command_id, want.last);
          $display("%0t:          got kind=%0d byte=%02h st=%0d len=%0d cmd=%02h last=%0d",
                   $realtime, got.kind, got.data_byte, got.status, got.frame_bytes,
                   got.command_id, got.last);
        end
      end
    end
  endtask

  // Result side.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop_i <= 1'b0;
      end else begin
        pop_i      <= 1'b1;
        stall_left = pick_gap(rx_burst);
      end
      @(negedge clk_i);
      if (pop_i && !empty_o) check_word(out_word_o);
    end
  end

  initial begin
    int unsigned goal;
    rows.insert(rows.size(),
                '{w: '{char_code: 8'h00, end_of_line: 1'b0}, typed: 1'b0, want: '0});
    add_line("\377x", 1'b1, ST_NO_START, 0, 8'h00);
    add_line("$", 1'b1, ST_SHORT, 0, 8'h00);
    add_line("$$", 1'b1, ST_BAD_HEX, 0, 8'h00);
    add_line("$\377", 1'b1, ST_BAD_HEX, 0, 8'h00);
    add_line("$1", 1'b1, ST_ODD, 0, 8'h00);
    add_line("$ a", 1'b1, ST_BAD_HEX, 0, 8'h00);
    add_line("$01c1C0 \t", 1'b1, ST_OK, 1, 8'h01);
    add_line("$FFFFFF", 1'b0, ST_OK, 0, 8'h00);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].typed) owed_q[owed_q.size() - 1] = rows[i].want;
    end

    // Keep offering words while the result side holds off, so the input stalls.
    hold_req = 1'b1;
    while (hold_req) send_random_line();

    while (chars_sent < 200) send_random_line();

    // Let every owed word drain before going on.
    push_i <= 1'b0;
    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    goal = chars_sent + 200;
    while (chars_sent < goal) send_random_line();
    push_i <= 1'b0;

    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && owed_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
